>>> hdl/vampire_fang_digit_check_macros.svh
// Assertion macros used by the checker file of the fang digit check.
`ifndef VAMPIRE_FANG_DIGIT_CHECK_MACROS_SVH
`define VAMPIRE_FANG_DIGIT_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/vfdc_pkg.sv
// Types and constants shared by the fang digit check modules.
package vfdc_pkg;

	// Input field widths.
	localparam int PRODUCT_BITS = 64;
	localparam int FANG_BITS    = 32;
	localparam int BIT_CNT_W    = 6;

	// One BCD digit and the number of digit values.
	localparam int DIGIT_W    = 4;
	localparam int NUM_VALUES = 10;

	// Controls for one chain of digit cells.
	typedef struct packed {
		logic clear;
		logic conv;
		logic shift;
	} vfdc_ctrl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_FIN
	} vfdc_state_t;

endpackage

>>> hdl/vfdc_in_if.sv
// Input channel: one candidate product and two candidate fangs per beat.
interface vfdc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] product_value;
	logic [31:0] fang_a;
	logic [31:0] fang_b;

	modport source (output valid, output product_value, output fang_a, output fang_b,
		input ready);
	modport sink (input valid, input product_value, input fang_a, input fang_b,
		output ready);
endinterface

>>> hdl/vfdc_out_if.sv
// Output channel: the three verdict flags per beat.
interface vfdc_out_if;
	logic valid;
	logic ready;
	logic digits_match;
	logic both_trailing_zero;
	logic is_vampire;

	modport source (output valid, output digits_match, output both_trailing_zero,
		output is_vampire, input ready);
	modport sink (input valid, input digits_match, input both_trailing_zero,
		input is_vampire, output ready);
endinterface

>>> hdl/vfdc_cell.sv
// One BCD digit cell: a double-dabble step during conversion, a digit shift during scan.
module vfdc_cell (
	input  logic                                clk,
	input  vfdc_pkg::vfdc_ctrl_t                ctrl,
	input  logic                                bit_in,
	input  logic [vfdc_pkg::DIGIT_W-1:0]        digit_in,
	output logic                                bit_out,
	output logic [vfdc_pkg::DIGIT_W-1:0]        digit
);

	logic [vfdc_pkg::DIGIT_W-1:0] digit_q;
	logic [vfdc_pkg::DIGIT_W-1:0] adj;

	// Add three to digits of five or more so that the doubling carries in decimal.
	always_comb begin
		adj = (digit_q >= vfdc_pkg::DIGIT_W'(5)) ? digit_q + vfdc_pkg::DIGIT_W'(3) : digit_q;
	end

	assign bit_out = adj[vfdc_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	// Digit register.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[vfdc_pkg::DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> hdl/vfdc_chain.sv
// A row of digit cells that converts a binary value to BCD and then shifts the
// digits out, most significant first, flagging which ones are significant.
module vfdc_chain #(
	parameter int DIGITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vfdc_pkg::vfdc_ctrl_t         ctrl,
	input  logic                         bit_in,
	output logic [vfdc_pkg::DIGIT_W-1:0] top_digit,
	output logic                         top_counted,
	output logic [vfdc_pkg::DIGIT_W-1:0] low_digit
);

	logic                         carry [DIGITS+1];
	logic [vfdc_pkg::DIGIT_W-1:0] dig   [DIGITS];
	logic                         seen_q;

	assign carry[0] = bit_in;

	// Cell i takes its bit and, when scanning, its digit from cell i-1.
	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		logic [vfdc_pkg::DIGIT_W-1:0] from_below;
		if (i == 0) begin : g_first
			assign from_below = '0;
		end else begin : g_rest
			assign from_below = dig[i-1];
		end
		vfdc_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (carry[i]),
			.digit_in (from_below),
			.bit_out  (carry[i+1]),
			.digit    (dig[i])
		);
	end

	assign top_digit   = dig[DIGITS-1];
	assign low_digit   = dig[0];
	assign top_counted = seen_q || (top_digit != '0);

	// A carry out of the top cell means nonzero digits lie above the row, so every
	// digit in the row is significant. Otherwise a digit counts once a nonzero one
	// has gone by above it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctrl.clear) begin
			seen_q <= 1'b0;
		end else if (ctrl.conv) begin
			seen_q <= seen_q || carry[DIGITS];
		end else if (ctrl.shift) begin
			seen_q <= top_counted;
		end
	end

endmodule

>>> hdl/vampire_fang_digit_check.sv
// Top level of the vampire fang digit check: sequencer, digit chains and tally.
//
//  Channel | Direction | Beat carries
//  req     | in        | product_value[63:0], fang_a[31:0], fang_b[31:0]
//  rsp     | out       | digits_match, both_trailing_zero, is_vampire
//
// Each item runs from accept to the next accept through the idle state that takes the
// beat, the double-dabble steps in the digit chains, a digit scan over every decimal
// slot and the FIN state that loads the result.
// Reset clears the sequencer, the chains' seen flags and the output valid; the rest of the datapath needs none.
// A stalled result holds in the output register while the next item is accepted
// and converted; the sequencer waits only when a second result is ready to go.
module vampire_fang_digit_check #(
	parameter int PRODUCT_DIGITS = 20,
	parameter int FANG_DIGITS    = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	vfdc_in_if.sink           req,
	vfdc_out_if.source        rsp
);

	localparam int SCAN_LEN = (PRODUCT_DIGITS > FANG_DIGITS) ? PRODUCT_DIGITS : FANG_DIGITS;
	localparam int SCAN_W   = $clog2(SCAN_LEN + 1);
	localparam int TALLY_W  = $clog2(PRODUCT_DIGITS + 2 * FANG_DIGITS + 1) + 1;
	localparam int CW       = vfdc_pkg::BIT_CNT_W;
	localparam int DW       = vfdc_pkg::DIGIT_W;

	vfdc_pkg::vfdc_state_t state_q, state_d;

	logic [vfdc_pkg::PRODUCT_BITS-1:0] prod_q;
	logic [vfdc_pkg::FANG_BITS-1:0]    fa_q;
	logic [vfdc_pkg::FANG_BITS-1:0]    fb_q;
	logic [CW-1:0]                     conv_cnt_q;
	logic [SCAN_W-1:0]                 scan_cnt_q;
	logic [TALLY_W-1:0]                tally_q [vfdc_pkg::NUM_VALUES];
	logic [TALLY_W-1:0]                tally_d [vfdc_pkg::NUM_VALUES];
	logic                              tz_q;
	logic                              out_valid_q;
	logic                              match_q;
	logic                              tzo_q;

	logic                  accept;
	logic                  load_out;
	logic                  fang_feed;
	logic                  p_active;
	logic                  f_active;
	logic                  all_zero;
	vfdc_pkg::vfdc_ctrl_t  p_ctrl;
	vfdc_pkg::vfdc_ctrl_t  f_ctrl;
	logic [DW-1:0]         p_top, a_top, b_top;
	logic [DW-1:0]         p_low, a_low, b_low;
	logic                  p_cnt, a_cnt, b_cnt;

	assign accept    = req.valid && req.ready;
	assign fang_feed = conv_cnt_q >= CW'(vfdc_pkg::PRODUCT_BITS - vfdc_pkg::FANG_BITS);
	assign p_active  = (state_q == vfdc_pkg::ST_SCAN) && (scan_cnt_q < SCAN_W'(PRODUCT_DIGITS));
	assign f_active  = (state_q == vfdc_pkg::ST_SCAN) && (scan_cnt_q < SCAN_W'(FANG_DIGITS));

	// Chain controls.
	always_comb begin
		p_ctrl.clear = accept;
		p_ctrl.conv  = (state_q == vfdc_pkg::ST_CONV);
		p_ctrl.shift = p_active;
		f_ctrl.clear = accept;
		f_ctrl.conv  = (state_q == vfdc_pkg::ST_CONV);
		f_ctrl.shift = f_active;
	end

	// Next state, input ready and result load.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			vfdc_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = vfdc_pkg::ST_CONV;
				end
			end
			vfdc_pkg::ST_CONV: begin
				if (conv_cnt_q == CW'(vfdc_pkg::PRODUCT_BITS - 1)) begin
					state_d = vfdc_pkg::ST_SCAN;
				end
			end
			vfdc_pkg::ST_SCAN: begin
				if (scan_cnt_q == SCAN_W'(SCAN_LEN - 1)) begin
					state_d = vfdc_pkg::ST_FIN;
				end
			end
			vfdc_pkg::ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = vfdc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vfdc_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vfdc_pkg::ST_IDLE;
			conv_cnt_q <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				conv_cnt_q <= '0;
				scan_cnt_q <= '0;
			end else if (state_q == vfdc_pkg::ST_CONV) begin
				conv_cnt_q <= conv_cnt_q + CW'(1);
			end else if (state_q == vfdc_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
			end
		end
	end

	// Binary shift registers feeding the chains, most significant bit first.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q <= req.product_value;
			fa_q   <= req.fang_a;
			fb_q   <= req.fang_b;
		end else if (state_q == vfdc_pkg::ST_CONV) begin
			prod_q <= {prod_q[vfdc_pkg::PRODUCT_BITS-2:0], 1'b0};
			if (fang_feed) begin
				fa_q <= {fa_q[vfdc_pkg::FANG_BITS-2:0], 1'b0};
				fb_q <= {fb_q[vfdc_pkg::FANG_BITS-2:0], 1'b0};
			end
		end
	end

	vfdc_chain #(.DIGITS(PRODUCT_DIGITS)) u_prod_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (p_ctrl),
		.bit_in      (prod_q[vfdc_pkg::PRODUCT_BITS-1]),
		.top_digit   (p_top),
		.top_counted (p_cnt),
		.low_digit   (p_low)
	);

	vfdc_chain #(.DIGITS(FANG_DIGITS)) u_fa_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (f_ctrl),
		.bit_in      (fang_feed && fa_q[vfdc_pkg::FANG_BITS-1]),
		.top_digit   (a_top),
		.top_counted (a_cnt),
		.low_digit   (a_low)
	);

	vfdc_chain #(.DIGITS(FANG_DIGITS)) u_fb_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (f_ctrl),
		.bit_in      (fang_feed && fb_q[vfdc_pkg::FANG_BITS-1]),
		.top_digit   (b_top),
		.top_counted (b_cnt),
		.low_digit   (b_low)
	);

	// Per-value tally: the product's digit adds one, each fang's digit takes one away.
	always_comb begin
		for (int d = 0; d < vfdc_pkg::NUM_VALUES; d++) begin
			tally_d[d] = tally_q[d]
				+ TALLY_W'(p_active && p_cnt && (p_top == DW'(d)))
				- TALLY_W'(f_active && a_cnt && (a_top == DW'(d)))
				- TALLY_W'(f_active && b_cnt && (b_top == DW'(d)));
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < vfdc_pkg::NUM_VALUES; d++) begin
			if (accept) begin
				tally_q[d] <= '0;
			end else if (state_q == vfdc_pkg::ST_SCAN) begin
				tally_q[d] <= tally_d[d];
			end
		end
	end

	// Both fangs end in zero when their lowest BCD digits are zero after conversion.
	always_ff @(posedge clk) begin
		if ((state_q == vfdc_pkg::ST_SCAN) && (scan_cnt_q == '0)) begin
			tz_q <= (a_low == '0) && (b_low == '0);
		end
	end

	// The digit multisets match when every tally ends at zero.
	always_comb begin
		all_zero = 1'b1;
		for (int d = 0; d < vfdc_pkg::NUM_VALUES; d++) begin
			if (tally_q[d] != '0) begin
				all_zero = 1'b0;
			end
		end
	end

	// The product chain's low digit is not needed beyond conversion.
	logic p_low_unused;
	assign p_low_unused = ^p_low;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			match_q <= all_zero;
			tzo_q   <= tz_q;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.digits_match       = match_q;
	assign rsp.both_trailing_zero = tzo_q;
	assign rsp.is_vampire         = match_q && !tzo_q;

endmodule

>>> hdl/vfdc_checker.sv
// Port-level checks of the fang digit check, bound to its top level.
`include "vampire_fang_digit_check_macros.svh"

module vfdc_checker (
	input logic         clk,
	input logic         arst_n,
	vfdc_in_if.sink     req,
	vfdc_out_if.source  rsp
);

	// The verdict is the digit match without both trailing zeros.
	`VFDC_ASSERT_NOW(a_verdict, clk, arst_n, rsp.valid, rsp.is_vampire == (rsp.digits_match && !rsp.both_trailing_zero), "is_vampire disagrees with the other flags")

	// One item at a time: the input closes right after a beat is taken.
	`VFDC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "input still ready after a beat was taken")

	// No result can appear in the cycle after an item was accepted.
	`VFDC_ASSERT_NEXT(a_no_instant_result, clk, arst_n, req.valid && req.ready, !$rose(rsp.valid), "result appeared one cycle after accept")

	// A stalled result holds its flags.
	`VFDC_ASSERT_NEXT(a_out_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.digits_match) && $stable(rsp.both_trailing_zero), "stalled result changed")

endmodule

bind vampire_fang_digit_check vfdc_checker u_vfdc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

>>> tb/testbench.sv
// Testbench for the vampire fang digit check: directed and random candidates against a digit tally.
`timescale 1ns / 1ps
module testbench;

	localparam int PRODUCT_DIGITS         = 20;
	localparam int FANG_DIGITS            = 10;
	localparam int CYCLE_LIMIT            = 1000000;
	localparam int DRAIN_CYCLES           = 120;
	localparam int HOLD_OFF_CYCLES        = 400;
	localparam int RANDOM_ITEMS_PER_PHASE = 560;
	localparam int HOLD_OFF_ITEMS         = 12;

	typedef logic [vfdc_pkg::PRODUCT_BITS-1:0] product_t;
	typedef logic [vfdc_pkg::FANG_BITS-1:0]    fang_t;

	// The three flags of one result beat.
	typedef struct packed {
		logic digits_match;
		logic both_trailing_zero;
		logic is_vampire;
	} verdict_t;

	// Shapes of random candidates.
	typedef enum int {
		CAND_MATCH,
		CAND_NEAR_MISS,
		CAND_TRAILING_ZERO,
		CAND_NOISE
	} cand_kind_t;

	logic clk;
	logic arst_n;

	vfdc_in_if  req_if();
	vfdc_out_if rsp_if();

	verdict_t expected_verdicts[$];
	int       fail_count;
	int       src_idle_pct;
	int       sink_idle_pct;
	int       stall_requests;

	vampire_fang_digit_check #(
		.PRODUCT_DIGITS(PRODUCT_DIGITS),
		.FANG_DIGITS(FANG_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Add the decimal digits of a value into the tally, with the given sign.
	function automatic void tally_digits(ref int tally[10], input product_t value,
		input int slots, input int sign);
		product_t rest;
		int       i;
		rest = value;
		for (i = 0; i < slots && rest != 0; i++) begin
			tally[int'(rest % 10)] += sign;
			rest /= 10;
		end
	endfunction

	// Expected flags for one candidate: product digits minus both fangs' digits.
	function automatic verdict_t predict_verdict(product_t product, fang_t fa, fang_t fb);
		int       tally[10];
		verdict_t v;
		foreach (tally[d]) tally[d] = 0;
		tally_digits(tally, product, PRODUCT_DIGITS, 1);
		tally_digits(tally, product_t'(fa), FANG_DIGITS, -1);
		tally_digits(tally, product_t'(fb), FANG_DIGITS, -1);
		v.digits_match = 1'b1;
		foreach (tally[d]) begin
			if (tally[d] != 0) v.digits_match = 1'b0;
		end
		v.both_trailing_zero = (fa % 10 == 0) && (fb % 10 == 0);
		v.is_vampire = v.digits_match && !v.both_trailing_zero;
		return v;
	endfunction

	// A fang with a random number of decimal digits; zero digits means the value zero.
	function automatic fang_t random_fang();
		int          n;
		logic [63:0] lo;
		logic [63:0] hi;
		n = $urandom_range(10, 0);
		if (n == 0) return '0;
		lo = 64'd1;
		repeat (n - 1) lo *= 10;
		hi = lo * 10 - 1;
		if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
		return fang_t'(lo + ({32'b0, $urandom} % (hi - lo + 1)));
	endfunction

	// Build one candidate. Matching kinds shuffle the fangs' digits into the product.
	function automatic void build_candidate(input cand_kind_t kind, output product_t product,
		output fang_t fa, output fang_t fb);
		byte unsigned digs[$];
		logic [127:0] acc;
		fang_t        rest;
		byte unsigned t;
		int           i;
		int           j;
		int           pos;
		do begin
			if (kind == CAND_NOISE) begin
				product = {$urandom, $urandom} >> $urandom_range(63, 0);
				fa = $urandom >> $urandom_range(31, 0);
				fb = $urandom >> $urandom_range(31, 0);
				return;
			end
			fa = random_fang();
			fb = random_fang();
			if (kind == CAND_TRAILING_ZERO) begin
				fa -= fa % 10;
				fb -= fb % 10;
			end
			digs.delete();
			rest = fa;
			while (rest != 0) begin
				digs.push_back(byte'(rest % 10));
				rest /= 10;
			end
			rest = fb;
			while (rest != 0) begin
				digs.push_back(byte'(rest % 10));
				rest /= 10;
			end

			// Break the match by one digit: changed, dropped or extra.
			if (kind == CAND_NEAR_MISS) begin
				if (digs.size() == 0) begin
					digs.push_back(byte'($urandom_range(9, 1)));
				end else begin
					pos = $urandom_range(digs.size() - 1, 0);
					case ($urandom_range(2, 0))
						0: begin
							digs[pos] = byte'((digs[pos] + $urandom_range(9, 1)) % 10);
						end
						1: begin
							digs.delete(pos);
						end
						default: begin
							digs.push_back(byte'($urandom_range(9, 0)));
						end
					endcase
				end
			end

			// Shuffle the digits into product order.
			for (i = digs.size() - 1; i > 0; i--) begin
				j = $urandom_range(i, 0);
				t = digs[i];
				digs[i] = digs[j];
				digs[j] = t;
			end

			// A leading zero silently drops a digit, so keep that case rare.
			if (digs.size() > 1 && digs[0] == 0 && $urandom_range(7, 0) != 0) begin
				for (i = 1; i < digs.size(); i++) begin
					if (digs[i] != 0) begin
						digs[0] = digs[i];
						digs[i] = 0;
						break;
					end
				end
			end

			acc = '0;
			foreach (digs[k]) acc = acc * 10 + digs[k];
		end while (acc > 128'hFFFF_FFFF_FFFF_FFFF);
		product = product_t'(acc);
	endfunction

	// Offer one beat after an optional gap and record its verdict once accepted.
	task automatic send_candidate(input product_t product, input fang_t fa, input fang_t fb);
		int gap;
		if ($urandom_range(99, 0) < src_idle_pct) begin
			gap = ($urandom_range(15, 0) == 0) ? $urandom_range(120, 1) : $urandom_range(3, 1);
			repeat (gap) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_if.valid         <= 1'b1;
		req_if.product_value <= product;
		req_if.fang_a        <= fa;
		req_if.fang_b        <= fb;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		expected_verdicts.push_back(predict_verdict(product, fa, fb));
	endtask

	// Known vampires, boundary values and the zero-digit cases.
	task automatic test_directed_cases();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_candidate(64'd0, 32'd0, 32'd0);
		send_candidate(64'd1260, 32'd21, 32'd60);
		send_candidate(64'd1395, 32'd15, 32'd93);
		send_candidate(64'd125460, 32'd204, 32'd615);
		send_candidate(64'd125460, 32'd246, 32'd510);
		send_candidate(64'd126000, 32'd210, 32'd600);
		send_candidate(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_candidate(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0);
		send_candidate(64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_candidate(64'd18446744073709551615, 32'd1844674407, 32'd3709551615);
		send_candidate(64'd10000000002244567999, 32'd4294967295, 32'd1000000000);
		send_candidate(64'd12, 32'd1, 32'd2);
		send_candidate(64'd102, 32'd10, 32'd2);
		send_candidate(64'd5, 32'd5, 32'd0);
		send_candidate(64'd50, 32'd5, 32'd0);
		send_candidate(64'd50, 32'd50, 32'd0);
		send_candidate(64'd11, 32'd1, 32'd11);
		send_candidate(64'd1020, 32'd21, 32'd0);
		send_candidate(64'h8000_0000_0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_candidate(64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
	endtask

	// Mostly digit permutations, with near misses, trailing zeros and raw noise.
	task automatic test_random_candidates(input int sender_idle, input int receiver_idle);
		product_t   p;
		fang_t      a;
		fang_t      b;
		cand_kind_t kind;
		int         r;
		src_idle_pct  = sender_idle;
		sink_idle_pct = receiver_idle;
		repeat (RANDOM_ITEMS_PER_PHASE) begin
			r = $urandom_range(99, 0);
			if (r < 55) kind = CAND_MATCH;
			else if (r < 75) kind = CAND_NEAR_MISS;
			else if (r < 87) kind = CAND_TRAILING_ZERO;
			else kind = CAND_NOISE;
			build_candidate(kind, p, a, b);
			send_candidate(p, a, b);
		end
	endtask

	// Receiver holds off for a long stretch while beats keep coming, so the input stalls.
	task automatic test_result_hold_off();
		product_t p;
		fang_t    a;
		fang_t    b;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		stall_requests++;
		repeat (HOLD_OFF_ITEMS) begin
			build_candidate(CAND_MATCH, p, a, b);
			send_candidate(p, a, b);
		end
	endtask

	// Result ready: random per cycle, or low through a requested hold-off.
	initial begin : result_receiver
		int hold_left;
		int served;
		hold_left    = 0;
		served       = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (served != stall_requests) begin
				served    = stall_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	// Compare one flag and report a mismatch.
	function automatic void check_flag(string name, logic want, logic got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
		end
	endfunction

	// Check every accepted result beat against the oldest expected verdict.
	always @(posedge clk) begin : verdict_checker
		verdict_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_verdicts.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result beat, expected none, actual %0b%0b%0b", $time,
					rsp_if.digits_match, rsp_if.both_trailing_zero, rsp_if.is_vampire);
			end else begin
				want = expected_verdicts.pop_front();
				check_flag("digits_match", want.digits_match, rsp_if.digits_match);
				check_flag("both_trailing_zero", want.both_trailing_zero,
					rsp_if.both_trailing_zero);
				check_flag("is_vampire", want.is_vampire, rsp_if.is_vampire);
			end
		end
	end

	// Cycle counter that ends a hung run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// Reset, run the tests in turn, drain and report.
	initial begin
		fail_count           = 0;
		src_idle_pct         = 0;
		sink_idle_pct        = 0;
		stall_requests       = 0;
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.product_value = '0;
		req_if.fang_a        = '0;
		req_if.fang_b        = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_candidates(25, 70);
		test_random_candidates(70, 25);
		test_result_hold_off();
		test_random_candidates(0, 0);

		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
